// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the order book block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define LOBL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("order book assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define LOBL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("order book sequencing assertion failed");

`endif

// ===== rtl/lobl_pkg.sv =====
package lobl_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned PriceW   = 32;
  localparam int unsigned QtyW     = 32;
  localparam int unsigned TotalW   = 48;
  localparam int unsigned CountW   = 11;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PosW     = 7;
  localparam int unsigned UsedOutW = 7;

  localparam logic [TotalW-1:0] TotalMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_MODIFY = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_DUP         = 3'd1,
    ST_TABLE_FULL  = 3'd2,
    ST_LEVELS_FULL = 3'd3,
    ST_UNKNOWN     = 3'd4
  } status_e;

  // Operation broadcast to every cell of one side.
  typedef enum logic [2:0] {
    CELL_NOP = 3'd0,
    CELL_CMP = 3'd1,
    CELL_INS = 3'd2,
    CELL_ADD = 3'd3,
    CELL_SUB = 3'd4,
    CELL_REM = 3'd5,
    CELL_CLR = 3'd6
  } cell_op_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KeyW-1:0]   order_key;
    logic [PriceW-1:0] limit_price;
    logic [QtyW-1:0]   order_qty;
    logic              is_sell;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [PosW-1:0]     level_position;
    logic [TotalW-1:0]   level_total;
    logic [CountW-1:0]   level_orders;
    logic [UsedOutW-1:0] bids_in_use;
    logic [UsedOutW-1:0] asks_in_use;
  } rsp_t;

  typedef struct packed {
    cell_op_e          op;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic              dec;
  } cell_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [PriceW-1:0] price;
    logic [TotalW-1:0] total;
    logic [CountW-1:0] count;
  } level_t;

  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic              side;
  } slot_t;

  // Saturating add of an order quantity to a level total.
  function automatic logic [TotalW-1:0] add_sat(logic [TotalW-1:0] a, logic [QtyW-1:0] b);
    logic [TotalW:0] sum;
    sum = {1'b0, a} + (TotalW + 1)'(b);
    return sum[TotalW] ? TotalMax : sum[TotalW-1:0];
  endfunction

  // Subtraction clamped at zero.
  function automatic logic [TotalW-1:0] sub_clamp(logic [TotalW-1:0] a, logic [QtyW-1:0] b);
    return (a > TotalW'(b)) ? (a - TotalW'(b)) : '0;
  endfunction

endpackage

// ===== rtl/lobl_req_if.sv =====
interface lobl_req_if;
  logic               valid;
  logic               ready;
  lobl_pkg::req_t     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lobl_rsp_if.sv =====
interface lobl_rsp_if;
  logic               valid;
  logic               ready;
  lobl_pkg::rsp_t     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lobl_slot_ram.sv =====
module lobl_slot_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Aw    = 10
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [Aw-1:0]         waddr_i,
  input  lobl_pkg::slot_t       wdata_i,
  input  logic [Aw-1:0]         raddr_i,
  output lobl_pkg::slot_t       rdata_o
);

  lobl_pkg::slot_t mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/lobl_level_cell.sv =====
module lobl_level_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lobl_pkg::cell_ctrl_t ctrl_i,
  input  logic                 sell_i,
  input  lobl_pkg::level_t     prev_i,
  input  logic                 prev_before_i,
  input  lobl_pkg::level_t     next_i,
  output lobl_pkg::level_t     lvl_o,
  output logic                 match_o,
  output logic                 before_o
);

  lobl_pkg::level_t lvl_q, lvl_d;
  logic             match_q, match_d;
  logic             before_q, before_d;

  // Each cell acts on its own level, taking its neighbour's when the list shifts.
  always_comb begin
    lvl_d    = lvl_q;
    match_d  = match_q;
    before_d = before_q;
    case (ctrl_i.op)
      lobl_pkg::CELL_CMP: begin
        match_d  = lvl_q.valid && (lvl_q.price == ctrl_i.price);
        before_d = lvl_q.valid && (sell_i ? (lvl_q.price < ctrl_i.price)
                                          : (lvl_q.price > ctrl_i.price));
      end
      lobl_pkg::CELL_INS: begin
        match_d = 1'b0;
        if (!before_q) begin
          if (prev_before_i) begin
            lvl_d.valid = 1'b1;
            lvl_d.price = ctrl_i.price;
            lvl_d.total = '0;
            lvl_d.count = '0;
            match_d     = 1'b1;
          end else begin
            lvl_d = prev_i;
          end
        end
      end
      lobl_pkg::CELL_ADD: begin
        // The order count only moves when an order joins the level.
        if (match_q) begin
          lvl_d.total = lobl_pkg::add_sat(lvl_q.total, ctrl_i.qty);
          if (ctrl_i.dec && (lvl_q.count != lobl_pkg::CountMax)) begin
            lvl_d.count = lvl_q.count + 1'b1;
          end
        end
      end
      lobl_pkg::CELL_SUB: begin
        if (match_q) begin
          lvl_d.total = lobl_pkg::sub_clamp(lvl_q.total, ctrl_i.qty);
          if (ctrl_i.dec && (lvl_q.count != '0)) begin
            lvl_d.count = lvl_q.count - 1'b1;
          end
        end
      end
      lobl_pkg::CELL_REM: begin
        match_d = 1'b0;
        if (lvl_q.valid && !before_q) begin
          lvl_d = next_i;
        end
      end
      lobl_pkg::CELL_CLR: begin
        lvl_d.valid = 1'b0;
        match_d     = 1'b0;
        before_d    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Level and control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q    <= '0;
      match_q  <= 1'b0;
      before_q <= 1'b0;
    end else begin
      lvl_q    <= lvl_d;
      match_q  <= match_d;
      before_q <= before_d;
    end
  end

  assign lvl_o    = lvl_q;
  assign match_o  = match_q;
  assign before_o = before_q;

endmodule

// ===== rtl/limit_order_book_levels.sv =====
// Price-level aggregation for a limit order book.
// Requests enter on req_i (valid/ready); each one gives exactly one beat on
// rsp_o carrying the status, the affected level and both level counts.
// Orders live in a table of ORDER_SLOTS entries (one write port, one read
// port) that is scanned one entry per cycle to find the key and the first
// free slot. Price levels of each side sit in a row of LEVEL_DEPTH cells
// that compare, insert, shift and update in parallel, one operation per cycle.
// Add, modify and cancel always scan the whole table before any level update
// and before the result beat; a clear sweeps the whole table, as after reset.
// One request is worked on at a time; req_i.ready is high while the block is
// idle, even when the previous result beat still waits in the output register.
// After reset the block sweeps the order table and accepts no request
// meanwhile. If the receiver stalls, the result is held in the output
// register and the next result waits until it is taken.
`include "assert_macros.svh"

module limit_order_book_levels #(
  parameter int unsigned LEVEL_DEPTH = 64,
  parameter int unsigned ORDER_SLOTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lobl_req_if.sink   req_i,
  lobl_rsp_if.source rsp_o
);

  localparam int unsigned Aw = $clog2(ORDER_SLOTS);
  localparam int unsigned Iw = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned Uw = $clog2(LEVEL_DEPTH + 1);

  typedef enum logic [9:0] {
    S_WIPE  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_LCMP  = 10'b0000001000,
    S_LDEC  = 10'b0000010000,
    S_LADD  = 10'b0000100000,
    S_LMOD2 = 10'b0001000000,
    S_LCHK  = 10'b0010000000,
    S_LRES  = 10'b0100000000,
    S_SEND  = 10'b1000000000
  } state_e;

  state_e                state_q, state_d;
  lobl_pkg::req_t        req_q, req_d;
  logic                  side_q, side_d;
  logic [31:0]           lprice_q, lprice_d;
  logic [31:0]           old_q, old_d;
  logic                  hit_q, hit_d;
  logic [Aw-1:0]         hit_idx_q, hit_idx_d;
  lobl_pkg::slot_t       hit_slot_q, hit_slot_d;
  logic                  free_q, free_d;
  logic [Aw-1:0]         free_idx_q, free_idx_d;
  logic [Aw:0]           issue_q, issue_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [Aw-1:0]         rd_idx_q, rd_idx_d;
  logic [Aw-1:0]         wipe_q, wipe_d;
  logic                  wipe_clr_q, wipe_clr_d;
  lobl_pkg::rsp_t        res_q, res_d;
  lobl_pkg::rsp_t        out_q, out_d;
  logic                  out_vld_q, out_vld_d;
  logic [Uw-1:0]         used_q [2];
  logic [Uw-1:0]         used_d [2];

  logic                  ram_we;
  logic [Aw-1:0]         ram_waddr;
  lobl_pkg::slot_t       ram_wdata;
  logic [Aw-1:0]         ram_raddr;
  lobl_pkg::slot_t       ram_rdata;

  lobl_pkg::cell_ctrl_t  ctrl [2];
  lobl_pkg::level_t      lvl [2][LEVEL_DEPTH];
  logic [LEVEL_DEPTH-1:0] match_v [2];
  logic [LEVEL_DEPTH-1:0] before_v [2];
  logic [LEVEL_DEPTH-1:0] valid_v [2];

  logic                  sel_any;
  logic [Iw-1:0]         sel_pos;
  logic [47:0]           sel_tot;
  logic [10:0]           sel_cnt;
  logic                  rem_fire;

  // Order table.
  lobl_slot_ram #(
    .Depth (ORDER_SLOTS),
    .Aw    (Aw)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Two rows of level cells: bids on side 0, asks on side 1.
  for (genvar s = 0; s < 2; s++) begin : g_side
    for (genvar i = 0; i < LEVEL_DEPTH; i++) begin : g_cell
      lobl_pkg::level_t prev_l, next_l;
      logic             prev_b;
      if (i == 0) begin : g_head
        assign prev_l = '0;
        assign prev_b = 1'b1;
      end else begin : g_body
        assign prev_l = lvl[s][i-1];
        assign prev_b = before_v[s][i-1];
      end
      if (i == LEVEL_DEPTH - 1) begin : g_tail
        assign next_l = '0;
      end else begin : g_link
        assign next_l = lvl[s][i+1];
      end
      lobl_level_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (ctrl[s]),
        .sell_i        (1'(s)),
        .prev_i        (prev_l),
        .prev_before_i (prev_b),
        .next_i        (next_l),
        .lvl_o         (lvl[s][i]),
        .match_o       (match_v[s][i]),
        .before_o      (before_v[s][i])
      );
      assign valid_v[s][i] = lvl[s][i].valid;
    end
  end

  // Pick out the matching level of the working side.
  always_comb begin
    sel_pos = '0;
    sel_tot = '0;
    sel_cnt = '0;
    sel_any = |match_v[side_q];
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      if (match_v[side_q][i]) begin
        sel_pos = sel_pos | Iw'(i);
        sel_tot = sel_tot | lvl[side_q][i].total;
        sel_cnt = sel_cnt | lvl[side_q][i].count;
      end
    end
  end

  // Request sequencer.
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    side_d     = side_q;
    lprice_d   = lprice_q;
    old_d      = old_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_slot_d = hit_slot_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    issue_d    = issue_q;
    rd_pend_d  = rd_pend_q;
    rd_idx_d   = rd_idx_q;
    wipe_d     = wipe_q;
    wipe_clr_d = wipe_clr_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    used_d[0]  = used_q[0];
    used_d[1]  = used_q[1];
    ram_we     = 1'b0;
    ram_waddr  = wipe_q;
    ram_wdata  = '0;
    ram_raddr  = issue_q[Aw-1:0];
    rem_fire   = 1'b0;
    for (int s = 0; s < 2; s++) begin
      ctrl[s].op    = lobl_pkg::CELL_NOP;
      ctrl[s].price = lprice_q;
      ctrl[s].qty   = req_q.order_qty;
      ctrl[s].dec   = 1'b0;
    end

    // The output register frees once its beat is taken.
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_WIPE: begin
        ram_we = 1'b1;
        wipe_d = wipe_q + 1'b1;
        if (wipe_q == Aw'(ORDER_SLOTS - 1)) begin
          state_d = wipe_clr_q ? S_SEND : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          req_d      = req_i.payload;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          issue_d    = '0;
          rd_pend_d  = 1'b0;
          wipe_clr_d = 1'b0;
          res_d      = '0;
          if (lobl_pkg::req_type_e'(req_i.payload.req_type) == lobl_pkg::REQ_CLEAR) begin
            ctrl[0].op = lobl_pkg::CELL_CLR;
            ctrl[1].op = lobl_pkg::CELL_CLR;
            used_d[0]  = '0;
            used_d[1]  = '0;
            wipe_d     = '0;
            wipe_clr_d = 1'b1;
            state_d    = S_WIPE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue one table read a cycle; check each entry as it returns.
        if (issue_q != (Aw + 1)'(ORDER_SLOTS)) begin
          issue_d   = issue_q + 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = issue_q[Aw-1:0];
        end else begin
          rd_pend_d = 1'b0;
        end
        if (rd_pend_q) begin
          if (ram_rdata.valid && (ram_rdata.key == req_q.order_key) && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = rd_idx_q;
            hit_slot_d = ram_rdata;
          end
          if (!ram_rdata.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
        if ((issue_q == (Aw + 1)'(ORDER_SLOTS)) && !rd_pend_q) begin
          case (lobl_pkg::req_type_e'(req_q.req_type))
            lobl_pkg::REQ_ADD: begin
              if (hit_q) begin
                res_d.status = lobl_pkg::ST_DUP;
                state_d      = S_SEND;
              end else if (!free_q) begin
                res_d.status = lobl_pkg::ST_TABLE_FULL;
                state_d      = S_SEND;
              end else begin
                side_d   = req_q.is_sell;
                lprice_d = req_q.limit_price;
                state_d  = S_LCMP;
              end
            end
            lobl_pkg::REQ_MODIFY, lobl_pkg::REQ_CANCEL: begin
              if (!hit_q) begin
                res_d.status = lobl_pkg::ST_UNKNOWN;
                state_d      = S_SEND;
              end else begin
                side_d   = hit_slot_q.side;
                lprice_d = hit_slot_q.price;
                old_d    = hit_slot_q.qty;
                state_d  = S_LCMP;
              end
            end
            default: begin
              state_d = S_SEND;
            end
          endcase
        end
      end
      S_LCMP: begin
        ctrl[side_q].op = lobl_pkg::CELL_CMP;
        state_d         = S_LDEC;
      end
      S_LDEC: begin
        case (lobl_pkg::req_type_e'(req_q.req_type))
          lobl_pkg::REQ_ADD: begin
            if (!sel_any && (used_q[side_q] >= Uw'(LEVEL_DEPTH))) begin
              res_d.status = lobl_pkg::ST_LEVELS_FULL;
              state_d      = S_SEND;
            end else begin
              if (!sel_any) begin
                ctrl[side_q].op = lobl_pkg::CELL_INS;
                used_d[side_q]  = used_q[side_q] + 1'b1;
              end
              state_d = S_LADD;
            end
          end
          lobl_pkg::REQ_MODIFY: begin
            ram_we        = 1'b1;
            ram_waddr     = hit_idx_q;
            ram_wdata     = hit_slot_q;
            ram_wdata.qty = req_q.order_qty;
            if (sel_any) begin
              ctrl[side_q].op  = lobl_pkg::CELL_SUB;
              ctrl[side_q].qty = old_q;
              state_d          = S_LMOD2;
            end else begin
              state_d = S_SEND;
            end
          end
          lobl_pkg::REQ_CANCEL: begin
            ram_we          = 1'b1;
            ram_waddr       = hit_idx_q;
            ram_wdata       = hit_slot_q;
            ram_wdata.valid = 1'b0;
            if (sel_any) begin
              ctrl[side_q].op  = lobl_pkg::CELL_SUB;
              ctrl[side_q].qty = old_q;
              ctrl[side_q].dec = 1'b1;
              state_d          = S_LCHK;
            end else begin
              state_d = S_SEND;
            end
          end
          default: begin
            state_d = S_SEND;
          end
        endcase
      end
      S_LADD: begin
        ctrl[side_q].op  = lobl_pkg::CELL_ADD;
        ctrl[side_q].dec = 1'b1;
        ram_we           = 1'b1;
        ram_waddr        = free_idx_q;
        ram_wdata.valid  = 1'b1;
        ram_wdata.key    = req_q.order_key;
        ram_wdata.price  = req_q.limit_price;
        ram_wdata.qty    = req_q.order_qty;
        ram_wdata.side   = req_q.is_sell;
        state_d          = S_LRES;
      end
      S_LMOD2: begin
        ctrl[side_q].op = lobl_pkg::CELL_ADD;
        state_d         = S_LRES;
      end
      S_LCHK: begin
        // A level left without orders leaves the list.
        if (sel_cnt == '0) begin
          ctrl[side_q].op      = lobl_pkg::CELL_REM;
          used_d[side_q]       = used_q[side_q] - 1'b1;
          rem_fire             = 1'b1;
          res_d.level_position = lobl_pkg::PosW'(sel_pos);
          state_d              = S_SEND;
        end else begin
          state_d = S_LRES;
        end
      end
      S_LRES: begin
        res_d.level_position = lobl_pkg::PosW'(sel_pos);
        res_d.level_total    = sel_tot;
        res_d.level_orders   = sel_cnt;
        state_d              = S_SEND;
      end
      S_SEND: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d             = res_q;
          out_d.bids_in_use = lobl_pkg::UsedOutW'(used_q[0]);
          out_d.asks_in_use = lobl_pkg::UsedOutW'(used_q[1]);
          out_vld_d         = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_WIPE;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      issue_q    <= '0;
      rd_pend_q  <= 1'b0;
      wipe_q     <= '0;
      wipe_clr_q <= 1'b0;
      out_vld_q  <= 1'b0;
      used_q[0]  <= '0;
      used_q[1]  <= '0;
    end else begin
      state_q    <= state_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      issue_q    <= issue_d;
      rd_pend_q  <= rd_pend_d;
      wipe_q     <= wipe_d;
      wipe_clr_q <= wipe_clr_d;
      out_vld_q  <= out_vld_d;
      used_q[0]  <= used_d[0];
      used_q[1]  <= used_d[1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    side_q     <= side_d;
    lprice_q   <= lprice_d;
    old_q      <= old_d;
    hit_idx_q  <= hit_idx_d;
    hit_slot_q <= hit_slot_d;
    free_idx_q <= free_idx_d;
    rd_idx_q   <= rd_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  // Valid cells always number exactly the level count of their side.
  `LOBL_ASSERT(a_bid_cells_used, clk_i, rst_ni, $countones(valid_v[0]) == used_q[0])
  `LOBL_ASSERT(a_ask_cells_used, clk_i, rst_ni, $countones(valid_v[1]) == used_q[1])
  // Prices are unique per side, so at most one cell matches.
  `LOBL_ASSERT(a_match_unique, clk_i, rst_ni, $onehot0(match_v[0]) && $onehot0(match_v[1]))
  // Removing an emptied level shrinks its side by exactly one.
  `LOBL_ASSERT_NEXT(a_remove_shrinks, clk_i, rst_ni, rem_fire,
    (used_q[side_q] + 1'b1) == $past(used_q[side_q]))

endmodule

// ===== bench/tb_limit_order_book_levels.sv =====
module tb_limit_order_book_levels;

  localparam int unsigned Depth = 64;
  localparam int unsigned Slots = 1024;
  localparam int unsigned RandItems = 140;
  localparam int unsigned FloodItems = 300;

  // Book mirror: predicts one result beat per accepted request and checks
  // each returned beat against the oldest prediction.
  class book_scoreboard;
    bit                 slot_live[Slots];
    logic [31:0]        slot_key[Slots];
    logic [31:0]        slot_px[Slots];
    logic [31:0]        slot_qty[Slots];
    bit                 slot_ask[Slots];
    logic [31:0]        lvl_px[2][Depth];
    logic [47:0]        lvl_tot[2][Depth];
    logic [10:0]        lvl_cnt[2][Depth];
    int                 lvl_used[2];
    lobl_pkg::rsp_t     expected_q[$];
    int                 errors;

    function int find_order(logic [31:0] key);
      for (int i = 0; i < Slots; i++)
        if (slot_live[i] && slot_key[i] == key) return i;
      return Slots;
    endfunction

    function int find_free();
      for (int i = 0; i < Slots; i++)
        if (!slot_live[i]) return i;
      return Slots;
    endfunction

    function int find_price(int sd, logic [31:0] p);
      for (int i = 0; i < lvl_used[sd]; i++)
        if (lvl_px[sd][i] == p) return i;
      return Depth;
    endfunction

    function logic [47:0] total_plus(logic [47:0] a, logic [31:0] b);
      logic [48:0] sum;
      sum = {1'b0, a} + 49'(b);
      return sum[48] ? lobl_pkg::TotalMax : sum[47:0];
    endfunction

    function logic [47:0] total_minus(logic [47:0] a, logic [31:0] b);
      return (a > 48'(b)) ? a - 48'(b) : '0;
    endfunction

    // Apply one request to the mirror and queue the expected beat.
    function void note_request(lobl_pkg::req_t r);
      lobl_pkg::rsp_t e;
      int             s;
      int             lv;
      int             sd;
      logic [31:0]    old;
      e = '0;
      case (lobl_pkg::req_type_e'(r.req_type))
        lobl_pkg::REQ_ADD: begin
          s = find_free();
          sd = int'(r.is_sell);
          lv = find_price(sd, r.limit_price);
          if (find_order(r.order_key) < Slots) begin
            e.status = lobl_pkg::ST_DUP;
          end else if (s >= Slots) begin
            e.status = lobl_pkg::ST_TABLE_FULL;
          end else if (lv >= Depth && lvl_used[sd] >= Depth) begin
            e.status = lobl_pkg::ST_LEVELS_FULL;
          end else begin
            // A new price is inserted in sorted order, the rest shift back.
            if (lv >= Depth) begin
              lv = 0;
              while (lv < lvl_used[sd] && (sd ? lvl_px[sd][lv] < r.limit_price
                                              : lvl_px[sd][lv] > r.limit_price))
                lv++;
              for (int i = lvl_used[sd]; i > lv; i--) begin
                lvl_px[sd][i] = lvl_px[sd][i-1];
                lvl_tot[sd][i] = lvl_tot[sd][i-1];
                lvl_cnt[sd][i] = lvl_cnt[sd][i-1];
              end
              lvl_px[sd][lv] = r.limit_price;
              lvl_tot[sd][lv] = '0;
              lvl_cnt[sd][lv] = '0;
              lvl_used[sd]++;
            end
            slot_live[s] = 1'b1;
            slot_key[s] = r.order_key;
            slot_px[s] = r.limit_price;
            slot_qty[s] = r.order_qty;
            slot_ask[s] = r.is_sell;
            lvl_tot[sd][lv] = total_plus(lvl_tot[sd][lv], r.order_qty);
            if (lvl_cnt[sd][lv] != lobl_pkg::CountMax) lvl_cnt[sd][lv]++;
            e.level_position = lobl_pkg::PosW'(lv);
            e.level_total = lvl_tot[sd][lv];
            e.level_orders = lvl_cnt[sd][lv];
          end
        end
        lobl_pkg::REQ_MODIFY, lobl_pkg::REQ_CANCEL: begin
          s = find_order(r.order_key);
          if (s >= Slots) begin
            e.status = lobl_pkg::ST_UNKNOWN;
          end else begin
            old = slot_qty[s];
            sd = int'(slot_ask[s]);
            lv = find_price(sd, slot_px[s]);
            if (lobl_pkg::req_type_e'(r.req_type) == lobl_pkg::REQ_MODIFY) begin
              slot_qty[s] = r.order_qty;
              if (lv < Depth) begin
                lvl_tot[sd][lv] = total_plus(total_minus(lvl_tot[sd][lv], old),
                                             r.order_qty);
                e.level_position = lobl_pkg::PosW'(lv);
                e.level_total = lvl_tot[sd][lv];
                e.level_orders = lvl_cnt[sd][lv];
              end
            end else begin
              slot_live[s] = 1'b0;
              if (lv < Depth) begin
                lvl_tot[sd][lv] = total_minus(lvl_tot[sd][lv], old);
                if (lvl_cnt[sd][lv] != 0) lvl_cnt[sd][lv]--;
                e.level_position = lobl_pkg::PosW'(lv);
                // An emptied level is removed and the rest move up.
                if (lvl_cnt[sd][lv] == 0) begin
                  for (int i = lv; i < lvl_used[sd] - 1; i++) begin
                    lvl_px[sd][i] = lvl_px[sd][i+1];
                    lvl_tot[sd][i] = lvl_tot[sd][i+1];
                    lvl_cnt[sd][i] = lvl_cnt[sd][i+1];
                  end
                  lvl_used[sd]--;
                end else begin
                  e.level_total = lvl_tot[sd][lv];
                  e.level_orders = lvl_cnt[sd][lv];
                end
              end
            end
          end
        end
        default: begin
          for (int i = 0; i < Slots; i++) slot_live[i] = 1'b0;
          lvl_used[0] = 0;
          lvl_used[1] = 0;
        end
      endcase
      e.bids_in_use = lobl_pkg::UsedOutW'(lvl_used[0]);
      e.asks_in_use = lobl_pkg::UsedOutW'(lvl_used[1]);
      expected_q.push_back(e);
    endfunction

    function void check_response(lobl_pkg::rsp_t got);
      lobl_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with no request outstanding: %p", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status != e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.level_position != e.level_position) begin
        $error("level_position: expected %0d, got %0d", e.level_position, got.level_position);
        errors++;
      end
      if (got.level_total != e.level_total) begin
        $error("level_total: expected %0d, got %0d", e.level_total, got.level_total);
        errors++;
      end
      if (got.level_orders != e.level_orders) begin
        $error("level_orders: expected %0d, got %0d", e.level_orders, got.level_orders);
        errors++;
      end
      if (got.bids_in_use != e.bids_in_use) begin
        $error("bids_in_use: expected %0d, got %0d", e.bids_in_use, got.bids_in_use);
        errors++;
      end
      if (got.asks_in_use != e.asks_in_use) begin
        $error("asks_in_use: expected %0d, got %0d", e.asks_in_use, got.asks_in_use);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lobl_req_if req_bus ();
  lobl_rsp_if rsp_bus ();

  int send_idle = 25;
  int recv_idle = 48;
  int hold_left = 0;
  book_scoreboard book = new();

  limit_order_book_levels dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #2 clk_i = ~clk_i;

  function automatic lobl_pkg::req_t make_req(lobl_pkg::req_type_e t, logic [31:0] key,
                                              logic [31:0] px, logic [31:0] qty,
                                              logic sell);
    lobl_pkg::req_t r;
    r.req_type = t;
    r.order_key = key;
    r.limit_price = px;
    r.order_qty = qty;
    r.is_sell = sell;
    return r;
  endfunction

  // Mostly keys from a small pool so that adds, modifies and cancels meet.
  function automatic lobl_pkg::req_t random_req();
    int                  roll;
    lobl_pkg::req_type_e t;
    logic [31:0]         key;
    logic [31:0]         px;
    logic [31:0]         qty;
    roll = $urandom_range(99);
    if (roll < 45) t = lobl_pkg::REQ_ADD;
    else if (roll < 70) t = lobl_pkg::REQ_MODIFY;
    else if (roll < 98) t = lobl_pkg::REQ_CANCEL;
    else t = lobl_pkg::REQ_CLEAR;
    key = ($urandom_range(9) == 0) ? $urandom : 32'h5A00_0000 + $urandom_range(39);
    px = ($urandom_range(7) == 0) ? $urandom : 32'd5000 + $urandom_range(24);
    qty = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
    return make_req(t, key, px, qty, 1'($urandom_range(1)));
  endfunction

  // Offer one beat, idling at random first, and log it once accepted.
  task automatic send_req(input lobl_pkg::req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.payload <= r;
    do @(posedge clk_i); while (!req_bus.ready);
    book.note_request(r);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check each accepted beat, then choose the next ready.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) book.check_response(rsp_bus.payload);
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    #(64'd40_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.payload = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: shared and new levels, extremes, rejects, level removal, clear.
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd1, 32'd100, 32'hFFFF_FFFF, 1'b0));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd2, 32'd100, 32'd7, 1'b0));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd3, 32'd200, 32'd5, 1'b0));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd4, 32'd50, 32'd1, 1'b0));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd5, 32'd0, 32'd0, 1'b1));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd9, 1'b1));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd6, 32'd300, 32'd3, 1'b1));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd1, 32'd999, 32'd1, 1'b1));
    send_req(make_req(lobl_pkg::REQ_MODIFY, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b1));
    send_req(make_req(lobl_pkg::REQ_MODIFY, 32'd2, 32'd0, 32'hFFFF_FFFF, 1'b0));
    send_req(make_req(lobl_pkg::REQ_MODIFY, 32'd77, 32'd100, 32'd1, 1'b0));
    send_req(make_req(lobl_pkg::REQ_CANCEL, 32'd3, 32'd0, 32'd0, 1'b1));
    send_req(make_req(lobl_pkg::REQ_CANCEL, 32'd2, 32'd0, 32'd0, 1'b0));
    send_req(make_req(lobl_pkg::REQ_CANCEL, 32'd0, 32'd0, 32'd0, 1'b0));
    send_req(make_req(lobl_pkg::REQ_CANCEL, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0));
    send_req(make_req(lobl_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      1'b1));
    send_req(make_req(lobl_pkg::REQ_CANCEL, 32'd1, 32'd0, 32'd0, 1'b0));
    send_req(make_req(lobl_pkg::REQ_ADD, 32'd1, 32'd100, 32'd4, 1'b1));
    send_req(make_req(lobl_pkg::REQ_CANCEL, 32'd1, 32'd0, 32'd0, 1'b0));

    // Random traffic, sender lighter on idling than the receiver.
    for (int i = 0; i < RandItems; i++) send_req(random_req());

    // Roles swapped, with one long receiver hold-off so the block backs up.
    send_idle = 48;
    recv_idle = 25;
    hold_left = 4000;
    for (int i = 0; i < RandItems; i++) send_req(random_req());

    // Flood with unique keys: fills the level lists of both sides.
    send_idle = 0;
    recv_idle = 0;
    send_req(make_req(lobl_pkg::REQ_CLEAR, 32'd0, 32'd0, 32'd0, 1'b0));
    for (int i = 0; i < FloodItems; i++)
      send_req(make_req(lobl_pkg::REQ_ADD, 32'hA000_0000 + i, $urandom_range(99), $urandom,
                        1'($urandom_range(1))));
    drain();
    for (int i = 0; i < 60; i++)
      send_req(make_req($urandom_range(1) ? lobl_pkg::REQ_MODIFY : lobl_pkg::REQ_CANCEL,
                        32'hA000_0000 + $urandom_range(FloodItems - 1), $urandom, $urandom,
                        1'($urandom_range(1))));
    send_req(make_req(lobl_pkg::REQ_CLEAR, 32'd0, 32'd0, 32'd0, 1'b0));

    // Neither side idles.
    for (int i = 0; i < RandItems; i++) send_req(random_req());

    drain();
    repeat (Slots + 20) @(posedge clk_i);
    if (book.errors == 0 && book.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lobl_pkg.sv
rtl/lobl_req_if.sv
rtl/lobl_rsp_if.sv
rtl/lobl_slot_ram.sv
rtl/lobl_level_cell.sv
rtl/limit_order_book_levels.sv
bench/tb_limit_order_book_levels.sv
